@@ rtl/core/ttd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types, constants and helpers of the tiled threshold dither block.
// ----------------------------------------------------------------------------
package ttd_pkg;

  // Default sizes of the pattern store and of the image.
  localparam int MAX_PATTERN_WIDTH_DEF  = 16;
  localparam int MAX_PATTERN_HEIGHT_DEF = 16;
  localparam int MAX_IMAGE_WIDTH_DEF    = 4096;
  localparam int MAX_IMAGE_HEIGHT_DEF   = 4096;

  // Register reset values.
  localparam int IMAGE_WIDTH_RST    = 640;
  localparam int IMAGE_HEIGHT_RST   = 480;
  localparam int PATTERN_WIDTH_RST  = 8;
  localparam int PATTERN_HEIGHT_RST = 8;

  // Depths of the command queue and of the result queue (powers of two).
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // Register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_PATTERN_WIDTH  = 2'd2,
    REG_PATTERN_HEIGHT = 2'd3
  } reg_index_t;

  // Item operations.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Output levels.
  localparam logic [7:0] LEVEL_WHITE = 8'd255;
  localparam logic [7:0] LEVEL_BLACK = 8'd0;

  // Input item as seen on the input channel.
  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_data_t;

  // Result item as seen on the output channel.
  typedef struct packed {
    logic [7:0] level;
    logic       frame_end;
  } out_data_t;

  // Classified command from the front to the back (store address travels apart).
  typedef struct packed {
    logic       op;
    logic [7:0] avg;
    logic       frame_end;
  } cmd_ctl_t;

  // Clamp a size to the range 1..mx.
  function automatic logic [31:0] clamp_size(logic [31:0] v, int unsigned mx);
    logic [31:0] res;
    if (v == 32'd0) begin
      res = 32'd1;
    end else if (v > mx) begin
      res = mx;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Floor of a sum of three bytes divided by three, by reciprocal multiply.
  function automatic logic [7:0] avg3(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [9:0]  sum;
    logic [20:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 21'(sum) * 21'd683;
    return prod[18:11];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ttd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_fifo
// Small register queue with show-ahead read data and a fill count.
// ----------------------------------------------------------------------------
module ttd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update; pointers wrap at the power-of-two depth.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule
`default_nettype wire

@@ rtl/core/ttd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_front
// Accepts items, averages the color, tracks load and pixel positions and
// issues one classified command per item; also holds the size registers.
// ----------------------------------------------------------------------------
module ttd_front #(
  parameter int MAX_PATTERN_WIDTH  = ttd_pkg::MAX_PATTERN_WIDTH_DEF,
  parameter int MAX_PATTERN_HEIGHT = ttd_pkg::MAX_PATTERN_HEIGHT_DEF,
  parameter int MAX_IMAGE_WIDTH    = ttd_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT   = ttd_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int AW                 = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire ttd_pkg::in_data_t               in_data,
  output logic                                 in_full,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 cmd_push,
  output ttd_pkg::cmd_ctl_t                    cmd_ctl,
  output logic      [AW-1:0]                   cmd_addr,
  input  wire logic                            cmd_full
);

  import ttd_pkg::*;

  localparam int IWW = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int IHW = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int PWW = $clog2(MAX_PATTERN_WIDTH + 1);
  localparam int PHW = $clog2(MAX_PATTERN_HEIGHT + 1);
  localparam int TCW = (MAX_PATTERN_WIDTH > 1) ? $clog2(MAX_PATTERN_WIDTH) : 1;
  localparam int TRW = (MAX_PATTERN_HEIGHT > 1) ? $clog2(MAX_PATTERN_HEIGHT) : 1;
  localparam int MW  = TRW + PWW + 1;

  logic [IWW-1:0] iw_r, iw_nxt;
  logic [IHW-1:0] ih_r, ih_nxt;
  logic [PWW-1:0] pw_r, pw_nxt;
  logic [PHW-1:0] ph_r, ph_nxt;
  logic [AW-1:0]  load_pos_r, load_pos_nxt;
  logic [IWW-1:0] pcol_r, pcol_nxt;
  logic [IHW-1:0] prow_r, prow_nxt;
  logic [TCW-1:0] tcol_r, tcol_nxt;
  logic [TRW-1:0] trow_r, trow_nxt;

  logic           accept;
  logic           cfg_wr;
  logic           col_wrap, row_wrap, tcol_wrap, trow_wrap, load_wrap;
  logic [MW-1:0]  tile_addr;
  logic [PWW+PHW-1:0] entries;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_full   = cmd_full;
  assign accept    = in_push && !cmd_full;

  // Wrap conditions of the position counters.
  assign entries   = (PWW + PHW)'(pw_r) * (PWW + PHW)'(ph_r);
  assign load_wrap = (32'(load_pos_r) + 32'd1) >= 32'(entries);
  assign col_wrap  = ({1'b0, pcol_r} + (IWW + 1)'(1)) >= {1'b0, iw_r};
  assign row_wrap  = ({1'b0, prow_r} + (IHW + 1)'(1)) >= {1'b0, ih_r};
  assign tcol_wrap = (32'(tcol_r) + 32'd1) >= 32'(pw_r);
  assign trow_wrap = (32'(trow_r) + 32'd1) >= 32'(ph_r);

  // Pattern entry of the current pixel: row times pattern width plus column.
  assign tile_addr = MW'(trow_r) * MW'(pw_r) + MW'(tcol_r);

  // Command issued to the back.
  always_comb begin
    cmd_push          = accept;
    cmd_ctl.op        = in_data.opcode;
    cmd_ctl.avg       = avg3(in_data.red, in_data.green, in_data.blue);
    cmd_ctl.frame_end = col_wrap && row_wrap;
    cmd_addr          = (in_data.opcode == OP_PIXEL) ? AW'(tile_addr) : load_pos_r;
  end

  // Next values of the size registers and the position counters.
  always_comb begin
    iw_nxt       = iw_r;
    ih_nxt       = ih_r;
    pw_nxt       = pw_r;
    ph_nxt       = ph_r;
    load_pos_nxt = load_pos_r;
    pcol_nxt     = pcol_r;
    prow_nxt     = prow_r;
    tcol_nxt     = tcol_r;
    trow_nxt     = trow_r;
    if (cfg_wr) begin
      load_pos_nxt = '0;
      pcol_nxt     = '0;
      prow_nxt     = '0;
      tcol_nxt     = '0;
      trow_nxt     = '0;
      case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          iw_nxt = IWW'(clamp_size(32'(cfg_data), MAX_IMAGE_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          ih_nxt = IHW'(clamp_size(32'(cfg_data), MAX_IMAGE_HEIGHT));
        end
        REG_PATTERN_WIDTH: begin
          pw_nxt = PWW'(clamp_size(32'(cfg_data[4:0]), MAX_PATTERN_WIDTH));
        end
        REG_PATTERN_HEIGHT: begin
          ph_nxt = PHW'(clamp_size(32'(cfg_data[4:0]), MAX_PATTERN_HEIGHT));
        end
        default: begin
          load_pos_nxt = load_pos_r;
        end
      endcase
    end else if (accept && (in_data.opcode == OP_LOAD)) begin
      load_pos_nxt = load_wrap ? '0 : load_pos_r + AW'(1);
    end else if (accept) begin
      tcol_nxt = tcol_wrap ? '0 : tcol_r + TCW'(1);
      pcol_nxt = pcol_r + IWW'(1);
      if (col_wrap) begin
        pcol_nxt = '0;
        tcol_nxt = '0;
        trow_nxt = trow_wrap ? '0 : trow_r + TRW'(1);
        prow_nxt = prow_r + IHW'(1);
        if (row_wrap) begin
          prow_nxt = '0;
          trow_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r       <= IWW'(clamp_size(32'(IMAGE_WIDTH_RST), MAX_IMAGE_WIDTH));
      ih_r       <= IHW'(clamp_size(32'(IMAGE_HEIGHT_RST), MAX_IMAGE_HEIGHT));
      pw_r       <= PWW'(clamp_size(32'(PATTERN_WIDTH_RST), MAX_PATTERN_WIDTH));
      ph_r       <= PHW'(clamp_size(32'(PATTERN_HEIGHT_RST), MAX_PATTERN_HEIGHT));
      load_pos_r <= '0;
      pcol_r     <= '0;
      prow_r     <= '0;
      tcol_r     <= '0;
      trow_r     <= '0;
    end else begin
      iw_r       <= iw_nxt;
      ih_r       <= ih_nxt;
      pw_r       <= pw_nxt;
      ph_r       <= ph_nxt;
      load_pos_r <= load_pos_nxt;
      pcol_r     <= pcol_nxt;
      prow_r     <= prow_nxt;
      tcol_r     <= tcol_nxt;
      trow_r     <= trow_nxt;
    end
  end

`ifndef SYNTH
  // The tile position always stays inside the configured pattern.
  a_tile_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(tcol_r) < 32'(pw_r)) && (32'(trow_r) < 32'(ph_r)))
    else $error("tile position outside pattern");

  // A pixel command addresses an entry of the configured pattern.
  a_addr_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == OP_PIXEL)) |-> (32'(tile_addr) < 32'(entries)))
    else $error("pixel address beyond pattern");

  // A configuration write restarts the pixel position.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> ((pcol_r == '0) && (prow_r == '0) && (load_pos_r == '0)))
    else $error("counters not restarted after register write");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ttd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_back
// Executes commands against the threshold store: loads write an entry,
// pixels read their entry and compare it with the gray value.
// ----------------------------------------------------------------------------
module ttd_back #(
  parameter int AW        = 8,
  parameter int DEPTH     = 256,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ttd_pkg::cmd_ctl_t                cmd_ctl,
  input  wire logic [AW-1:0]                    cmd_addr,
  input  wire logic                             cmd_empty,
  output logic                                  cmd_pop,
  output logic                                  res_push,
  output ttd_pkg::out_data_t                    res_data,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   res_count,
  input  wire logic                             res_full
);

  import ttd_pkg::*;

  logic [7:0] store_r [DEPTH];
  logic [7:0] thr_r;
  logic [7:0] avg_r;
  logic       frame_end_r;
  logic       s1_valid_r, s1_valid_nxt;

  // Issue a command only while the result queue has room for it and for
  // the pixel already in flight.
  assign cmd_pop      = !cmd_empty &&
                        ((32'(res_count) + 32'(s1_valid_r)) < 32'(OUT_DEPTH));
  assign s1_valid_nxt = cmd_pop && (cmd_ctl.op == OP_PIXEL);

  // Threshold store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd_ctl.op == OP_LOAD)) begin
      store_r[cmd_addr] <= cmd_ctl.avg;
    end
    thr_r <= store_r[cmd_addr];
  end

  // Pixel payload held beside the store read.
  always_ff @(posedge clk) begin
    avg_r       <= cmd_ctl.avg;
    frame_end_r <= cmd_ctl.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Compare and hand the result to the output queue.
  always_comb begin
    res_push           = s1_valid_r;
    res_data.level     = (avg_r > thr_r) ? LEVEL_WHITE : LEVEL_BLACK;
    res_data.frame_end = frame_end_r;
  end

`ifndef SYNTH
  // The credit check keeps the result queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // A result follows in the cycle after each issued pixel command.
  a_result_follows_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd_ctl.op == OP_PIXEL)) |=> res_push)
    else $error("pixel command lost");

  // Load commands never produce a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd_ctl.op == OP_LOAD)) |=> !res_push)
    else $error("load command produced a result");
`endif

endmodule
`default_nettype wire

@@ rtl/core/tiled_threshold_dither.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tiled_threshold_dither
// Ordered dither of a pixel stream against a loadable tiled threshold pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on a queue-like port: a transfer happens when in_push
//   is high and in_full is low. Opcode 0 loads the next pattern texel, opcode 1
//   dithers the next pixel. Results leave on a queue-like port: while out_empty
//   is low the oldest result is on out_data, and a transfer happens when
//   out_pop is high. Load items give no result.
//   Throughput is one item per cycle while in_full is low. A pixel passes the
//   command queue, the registered store read and the result queue.
//   A front part averages the color and tracks positions, a four-entry command
//   queue feeds the back part, which writes or reads the threshold store and
//   compares; a four-entry result queue decouples the receiver.
//   When the receiver stalls, the result queue fills, the back part stops,
//   then the command queue fills and in_full rises; nothing is dropped.
//   Reset (rst_n low, synchronous) empties both queues, zeroes all positions
//   and restores the sizes to 640 by 480 and an 8 by 8 pattern. The threshold
//   store is not cleared: load the pattern before dithering.
//   Size registers are written through cfg_valid/cfg_ready only while idle, a
//   user rule the block does not enforce; each write restarts load and pixel positions.
// ----------------------------------------------------------------------------
module tiled_threshold_dither #(
  parameter int MAX_PATTERN_WIDTH  = ttd_pkg::MAX_PATTERN_WIDTH_DEF,
  parameter int MAX_PATTERN_HEIGHT = ttd_pkg::MAX_PATTERN_HEIGHT_DEF,
  parameter int MAX_IMAGE_WIDTH    = ttd_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT   = ttd_pkg::MAX_IMAGE_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire ttd_pkg::in_data_t               in_data,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output ttd_pkg::out_data_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ttd_pkg::*;

  localparam int DEPTH = MAX_PATTERN_WIDTH * MAX_PATTERN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMDW  = $bits(cmd_ctl_t) + AW;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);
  localparam int CCW   = $clog2(CMD_DEPTH + 1);

  cmd_ctl_t        f_ctl, b_ctl;
  logic [AW-1:0]   f_addr, b_addr;
  logic            f_push, cmd_full, cmd_empty, cmd_pop;
  logic [CCW-1:0]  cmd_count;
  logic            res_push, res_full;
  out_data_t       res_data;
  logic [OCW-1:0]  res_count;
  logic [CMDW-1:0] cmd_rd;

  ttd_front #(
    .MAX_PATTERN_WIDTH  (MAX_PATTERN_WIDTH),
    .MAX_PATTERN_HEIGHT (MAX_PATTERN_HEIGHT),
    .MAX_IMAGE_WIDTH    (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT   (MAX_IMAGE_HEIGHT),
    .AW                 (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (f_push),
    .cmd_ctl   (f_ctl),
    .cmd_addr  (f_addr),
    .cmd_full  (cmd_full)
  );

  // Command queue between the front and the back.
  ttd_fifo #(
    .WIDTH (CMDW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data ({f_ctl, f_addr}),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign b_ctl  = cmd_ctl_t'(cmd_rd[CMDW-1:AW]);
  assign b_addr = cmd_rd[AW-1:0];

  ttd_back #(
    .AW        (AW),
    .DEPTH     (DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ctl   (b_ctl),
    .cmd_addr  (b_addr),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_count (res_count),
    .res_full  (res_full)
  );

  // Result queue toward the receiver.
  ttd_fifo #(
    .WIDTH ($bits(out_data_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .pop     (out_pop),
    .rd_data (out_data),
    .full    (res_full),
    .empty   (out_empty),
    .count   (res_count)
  );

`ifndef SYNTH
  // The command queue count agrees with its flags.
  a_cmd_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_empty == (cmd_count == '0)) && (cmd_full == (cmd_count == CCW'(CMD_DEPTH))))
    else $error("command queue flags inconsistent");

  // Back pressure reaches the input only through a full command queue.
  a_full_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_full == cmd_full)
    else $error("input full not from command queue");

  // The back never issues from an empty command queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");
`endif

endmodule
`default_nettype wire

@@ tb/tiled_threshold_dither_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_threshold_dither_tb
// Self-checking bench for the tiled threshold dither. A clocked driver feeds
// texel loads and pixels from a queue that the stimulus fills phase by phase.
// Size registers are rewritten between phases while the block is idle. A
// clocked monitor keeps its own copy of the threshold store and of the
// positions, predicts every pixel level and frame end, and compares each
// result transfer with the oldest prediction. Both sides stall at random,
// except in one long phase that runs without stalls.
// ----------------------------------------------------------------------------
module tiled_threshold_dither_tb;
  import ttd_pkg::*;

  localparam int STORE_DEPTH = MAX_PATTERN_WIDTH_DEF * MAX_PATTERN_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;
  localparam int RANDOM_PHASES = 10;

  // Block ports.
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  in_data_t               in_data = '0;
  logic                   in_full;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  out_data_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Stimulus and checking bookkeeping.
  in_data_t  items_to_send[$];
  out_data_t levels_due[$];
  logic      in_fire = 1'b0;
  logic      steady = 1'b0;
  int        mismatches = 0;
  int        cycle_count = 0;

  // Predicted block state.
  logic [7:0]  thr_store [0:STORE_DEPTH-1];
  logic [7:0]  load_pos;
  logic [11:0] pix_col;
  logic [11:0] pix_row;
  logic [3:0]  tile_col;
  logic [3:0]  tile_row;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [4:0]  pat_w;
  logic [4:0]  pat_h;

  // What the stimulus knows: pattern size and how much of the store is loaded.
  int plan_pw = PATTERN_WIDTH_RST;
  int plan_ph = PATTERN_HEIGHT_RST;
  int phase_loads = 0;
  int written_len = 0;

  tiled_threshold_dither i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sizes of 0 act as 1 and sizes above the maximum act as the maximum.
  function automatic int unsigned fit_size(int unsigned v, int unsigned top);
    if (v == 0) begin
      return 1;
    end
    return (v > top) ? top : v;
  endfunction

  function automatic logic pause_now();
    return !steady && ($urandom_range(99) < 7);
  endfunction

  // Mostly uniform channel values, with the extremes now and then.
  function automatic logic [7:0] pick_channel();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic restart_positions();
    load_pos = '0;
    pix_col  = '0;
    pix_row  = '0;
    tile_col = '0;
    tile_row = '0;
  endtask

  task automatic apply_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w = 13'(fit_size(val, MAX_IMAGE_WIDTH_DEF));
      end
      REG_IMAGE_HEIGHT: begin
        img_h = 13'(fit_size(val, MAX_IMAGE_HEIGHT_DEF));
      end
      REG_PATTERN_WIDTH: begin
        pat_w = 5'(fit_size(val[4:0], MAX_PATTERN_WIDTH_DEF));
      end
      REG_PATTERN_HEIGHT: begin
        pat_h = 5'(fit_size(val[4:0], MAX_PATTERN_HEIGHT_DEF));
      end
      default: begin
      end
    endcase
    restart_positions();
  endtask

  // Loads write the next store entry; pixels compare their gray value with the
  // threshold at the current pattern position and advance the positions.
  task automatic dither_item(in_data_t it);
    logic [7:0]  gray;
    int unsigned slot;
    out_data_t   res;
    gray = 8'((10'(it.red) + 10'(it.green) + 10'(it.blue)) / 10'd3);
    if (it.opcode == OP_LOAD) begin
      thr_store[load_pos] = gray;
      if (int'(load_pos) + 1 >= int'(pat_w) * int'(pat_h)) begin
        load_pos = '0;
      end else begin
        load_pos = load_pos + 8'd1;
      end
    end else begin
      slot = tile_row * pat_w + tile_col;
      res.level = (gray > thr_store[slot]) ? LEVEL_WHITE : LEVEL_BLACK;
      res.frame_end = (int'(pix_col) + 1 >= int'(img_w)) &&
                      (int'(pix_row) + 1 >= int'(img_h));
      levels_due.push_back(res);

      tile_col = (int'(tile_col) + 1 >= int'(pat_w)) ? 4'd0 : tile_col + 4'd1;
      if (int'(pix_col) + 1 >= int'(img_w)) begin
        pix_col  = '0;
        tile_col = '0;
        tile_row = (int'(tile_row) + 1 >= int'(pat_h)) ? 4'd0 : tile_row + 4'd1;
        if (int'(pix_row) + 1 >= int'(img_h)) begin
          pix_row  = '0;
          tile_row = '0;
        end else begin
          pix_row = pix_row + 12'd1;
        end
      end else begin
        pix_col = pix_col + 12'd1;
      end
    end
  endtask

  // Driver: offers the next pending item once the current one has been taken.
  always @(negedge clk) begin : feed_items
    logic     offer;
    in_data_t next_item;
    offer = 1'b0;
    next_item = in_data;
    if (in_push && !in_fire) begin
      offer = 1'b1;
    end else if (items_to_send.size() != 0 && !pause_now()) begin
      offer = 1'b1;
      next_item = items_to_send.pop_front();
    end
    in_push <= offer;
    in_data <= next_item;
    out_pop <= !pause_now();
  end

  // Monitor: checks result transfers, then follows register writes and items.
  always @(posedge clk) begin : watch_ports
    out_data_t want;
    in_fire = rst_n && in_push && !in_full;
    if (!rst_n) begin
      img_w = 13'(IMAGE_WIDTH_RST);
      img_h = 13'(IMAGE_HEIGHT_RST);
      pat_w = 5'(PATTERN_WIDTH_RST);
      pat_h = 5'(PATTERN_HEIGHT_RST);
      restart_positions();
    end else begin
      if (out_pop && !out_empty) begin
        if (levels_due.size() == 0) begin
          report_mismatch("result with nothing due, level", out_data.level, -1);
        end else begin
          want = levels_due.pop_front();
          if (out_data.level !== want.level) begin
            report_mismatch("level", out_data.level, want.level);
          end
          if (out_data.frame_end !== want.frame_end) begin
            report_mismatch("frame_end", out_data.frame_end, want.frame_end);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(reg_index_t'(cfg_index), cfg_data);
      end
      if (in_fire) begin
        dither_item(in_data);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tiled_threshold_dither: mismatch");
      $finish;
    end
  end

  // Queue one item and keep track of how far the store has been loaded.
  task automatic queue_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_data_t it;
    int       reach;
    it.opcode = op;
    it.red    = r;
    it.green  = g;
    it.blue   = b;
    items_to_send.push_back(it);
    if (op == OP_LOAD) begin
      phase_loads++;
      reach = (phase_loads < plan_pw * plan_ph) ? phase_loads : plan_pw * plan_ph;
      if (reach > written_len) begin
        written_len = reach;
      end
    end
  endtask

  // Pixels may only read loaded entries, so load the whole pattern if needed.
  task automatic fill_pattern();
    while (written_len < plan_pw * plan_ph) begin
      queue_item(OP_LOAD, pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  // Wait until every item was taken and every result came out, then let the
  // pipeline run dry, since trailing loads give no result.
  task automatic settle();
    do begin
      @(posedge clk);
    end while (items_to_send.size() != 0 || in_push || levels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    // Every write restarts the load position.
    phase_loads = 0;
    if (idx == REG_PATTERN_WIDTH) begin
      plan_pw = fit_size(val[4:0], MAX_PATTERN_WIDTH_DEF);
    end else if (idx == REG_PATTERN_HEIGHT) begin
      plan_ph = fit_size(val[4:0], MAX_PATTERN_HEIGHT_DEF);
    end
  endtask

  // Stimulus.
  initial begin : stimulus
    int         start;
    int         count;
    int         pick;
    reg_index_t idx;
    logic [CFG_DATA_W-1:0] val;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes: load the 8 by 8 pattern, then gray extremes and rounding.
    fill_pattern();
    queue_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    queue_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    queue_item(OP_PIXEL, 8'd255, 8'd255, 8'd254);
    queue_item(OP_PIXEL, 8'd1, 8'd1, 8'd0);
    queue_item(OP_PIXEL, 8'd1, 8'd1, 8'd1);
    repeat (3) queue_item(OP_PIXEL, pick_channel(), pick_channel(), pick_channel());

    // One by one pattern and image: every pixel ends a frame, every load wraps.
    // Pattern sizes of zero act as one.
    write_reg(REG_PATTERN_WIDTH, 13'h0000);
    write_reg(REG_PATTERN_HEIGHT, {8'hFF, 5'd0});
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    queue_item(OP_LOAD, 8'd0, 8'd0, 8'd0);
    queue_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    queue_item(OP_PIXEL, 8'd1, 8'd1, 8'd1);
    queue_item(OP_LOAD, 8'd255, 8'd255, 8'd255);
    queue_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    queue_item(OP_PIXEL, 8'd255, 8'd255, 8'd254);
    queue_item(OP_LOAD, 8'd0, 8'd0, 8'd3);
    queue_item(OP_PIXEL, 8'd1, 8'd1, 8'd1);

    // Sizes above their maximum act as the maximum; an image height of zero as one.
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    write_reg(REG_PATTERN_WIDTH, 13'h1F);
    write_reg(REG_PATTERN_HEIGHT, 13'd1);
    fill_pattern();
    repeat (5) queue_item(OP_PIXEL, pick_channel(), pick_channel(), pick_channel());

    // Largest legal sizes exactly.
    write_reg(REG_IMAGE_WIDTH, 13'(MAX_IMAGE_WIDTH_DEF));
    write_reg(REG_IMAGE_HEIGHT, 13'(MAX_IMAGE_HEIGHT_DEF));
    write_reg(REG_PATTERN_WIDTH, 13'(MAX_PATTERN_WIDTH_DEF));
    write_reg(REG_PATTERN_HEIGHT, 13'(MAX_PATTERN_HEIGHT_DEF));
    fill_pattern();
    repeat (4) queue_item(OP_PIXEL, pick_channel(), pick_channel(), pick_channel());

    // Random phases: small frames so that frames end often, random patterns,
    // loads mixed into the pixel stream. One long phase runs without stalls.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      start = $urandom_range(3);
      for (int i = 0; i < 4; i++) begin
        idx = reg_index_t'((start + i) % 4);
        pick = $urandom_range(15);
        case (idx)
          REG_IMAGE_WIDTH: begin
            if (pick == 0) begin
              val = '0;
            end else if (pick == 1) begin
              val = 13'($urandom_range(8191, 4096));
            end else if (pick == 2) begin
              val = 13'($urandom_range(300, 13));
            end else begin
              val = 13'($urandom_range(12, 1));
            end
          end
          REG_IMAGE_HEIGHT: begin
            if (pick == 0) begin
              val = '0;
            end else if (pick == 1) begin
              val = 13'($urandom_range(8191, 4096));
            end else begin
              val = 13'($urandom_range(6, 1));
            end
          end
          default: begin
            val = {8'($urandom_range(255)),
                   (pick < 4) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1))};
          end
        endcase
        write_reg(idx, val);
      end
      fill_pattern();
      steady = (phase == 3);
      count = (phase == 3) ? 300 : 80;
      repeat (count) begin
        if ($urandom_range(3) == 0) begin
          queue_item(OP_LOAD, pick_channel(), pick_channel(), pick_channel());
        end else begin
          queue_item(OP_PIXEL, pick_channel(), pick_channel(), pick_channel());
        end
      end
      settle();
      steady = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("tiled_threshold_dither: match");
    end else begin
      $display("tiled_threshold_dither: mismatch");
    end
    $finish;
  end

endmodule
